### hw/rtl/salc_pkg.sv
// Shared constants, codes and types of the LRU cache tag store.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned MaxWaysDef      = 8;
  localparam int unsigned MaxIndexBitsDef = 6;
  localparam int unsigned AddrWidthDef    = 64;

  // Fixed field widths
  localparam int unsigned AddrFieldW = 64;
  localparam int unsigned OutcomeW   = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 5;
  localparam int unsigned OffsetRegW = 5;
  localparam int unsigned IndexRegW  = 3;
  localparam int unsigned WaysRegW   = 4;

  localparam int unsigned MaxOffsetBits = 16;

  // Register reset values
  localparam logic [OffsetRegW-1:0] OffsetBitsRst = 5'd4;
  localparam logic [IndexRegW-1:0]  IndexBitsRst  = 3'd6;
  localparam logic [WaysRegW-1:0]   WaysInUseRst  = 4'd8;

  typedef enum logic [OutcomeW-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  // Controller to datapath commands
  typedef struct packed {
    logic lookup;  // read the set row, capture set and tag
    logic commit;  // write the row back and load the result
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/salc_if.sv
// Request and response channel interfaces of the LRU cache tag store.
`timescale 1ns / 1ps
`default_nettype none

interface salc_req_if;
  logic                             valid;
  logic                             ready;
  logic [salc_pkg::AddrFieldW-1:0]  address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface salc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [salc_pkg::OutcomeW-1:0]  outcome;

  modport source (output valid, output outcome, input ready);
  modport sink   (input valid, input outcome, output ready);
endinterface

`default_nettype wire

### hw/rtl/salc_ctrl.sv
// Controller state machine: lookup sequencing and result register handshake.
`timescale 1ns / 1ps
`default_nettype none

module salc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output salc_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_LOOKUP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, commit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  // the result register must be empty or draining before a new result lands
  assign commit      = (state_q == S_LOOKUP) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign cmd_o.lookup = accept;
  assign cmd_o.commit = commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/salc_datapath.sv
// Datapath: set/tag split, tag and recency memories, hit search and LRU update.
`timescale 1ns / 1ps
`default_nettype none

module salc_datapath #(
  parameter int unsigned MAX_WAYS       = salc_pkg::MaxWaysDef,
  parameter int unsigned MAX_INDEX_BITS = salc_pkg::MaxIndexBitsDef,
  parameter int unsigned ADDR_WIDTH     = salc_pkg::AddrWidthDef,
  localparam int unsigned CntW = $clog2(MAX_WAYS + 1),
  localparam int unsigned IbW  = $clog2(MAX_INDEX_BITS + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire salc_pkg::cmd_t                      cmd_i,
  input  wire logic [salc_pkg::AddrFieldW-1:0]     address_i,
  input  wire logic [salc_pkg::OffsetRegW-1:0]     offset_bits_i,
  input  wire logic [IbW-1:0]                      index_bits_i,
  input  wire logic [CntW-1:0]                     ways_i,
  output logic [salc_pkg::OutcomeW-1:0]            outcome_o
);

  localparam int unsigned NumSets = 1 << MAX_INDEX_BITS;
  localparam int unsigned IdxW    = MAX_INDEX_BITS;
  localparam int unsigned WayW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned TagW    = ADDR_WIDTH - 2;
  localparam int unsigned ShW     = $clog2(salc_pkg::MaxOffsetBits + MAX_INDEX_BITS + 1);

  // Row memories, one row per set
  logic [MAX_WAYS-1:0][TagW-1:0] tag_mem  [NumSets];
  logic [MAX_WAYS-1:0][WayW-1:0] rank_mem [NumSets];
  logic [CntW-1:0]               fill_mem [NumSets];
  logic [NumSets-1:0]            set_vld_q;

  logic [MAX_WAYS-1:0][TagW-1:0] tag_row_q, tag_row_d;
  logic [MAX_WAYS-1:0][WayW-1:0] rank_row_q, rank_row_d;
  logic [CntW-1:0]               fill_row_q, fill_row_d;
  logic                          valid_q;
  logic [IdxW-1:0]               set_q;
  logic [TagW-1:0]               tag_q;
  salc_pkg::outcome_e            outcome_q, outcome_d;

  // Address split
  logic [ADDR_WIDTH-1:0] addr_w, set_sh, tag_sh;
  logic [IdxW-1:0]       idx_mask, set_idx;
  logic [TagW-1:0]       tag_new;

  assign addr_w  = address_i[ADDR_WIDTH-1:0];
  assign set_sh  = addr_w >> offset_bits_i;
  assign tag_sh  = addr_w >> (ShW'(offset_bits_i) + ShW'(index_bits_i));
  assign set_idx = set_sh[IdxW-1:0] & idx_mask;
  assign tag_new = tag_sh[TagW-1:0];

  always_comb begin
    for (int b = 0; b < IdxW; b++) begin
      idx_mask[b] = (IbW'(b) < index_bits_i);
    end
  end

  // Hit search and recency update
  logic [CntW-1:0] filled, ways_m1, limit, count;
  logic            hit_found, vict_found, move_tgt, write_tag;
  logic [WayW-1:0] hit_way, vict_way, tgt_way;
  logic [WayW-1:0] hit_rank;

  assign ways_m1 = ways_i - CntW'(1);

  always_comb begin
    filled = valid_q ? fill_row_q : '0;
    if (filled > CntW'(MAX_WAYS)) filled = CntW'(MAX_WAYS);

    hit_found  = 1'b0;
    hit_way    = '0;
    hit_rank   = '0;
    vict_found = 1'b0;
    vict_way   = '0;
    // descending so the lowest matching way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (CntW'(w) < filled) begin
        if (CntW'(rank_row_q[w]) < ways_i && tag_row_q[w] == tag_q) begin
          hit_found = 1'b1;
          hit_way   = WayW'(w);
          hit_rank  = rank_row_q[w];
        end
        if (CntW'(rank_row_q[w]) == ways_m1) begin
          vict_found = 1'b1;
          vict_way   = WayW'(w);
        end
      end
    end

    priority if (hit_found) begin
      outcome_d  = salc_pkg::OUT_HIT;
      tgt_way    = hit_way;
      limit      = CntW'(hit_rank);
      count      = filled;
      move_tgt   = 1'b1;
      write_tag  = 1'b0;
      fill_row_d = filled;
    end else if (filled < ways_i) begin
      outcome_d  = salc_pkg::OUT_FILL;
      tgt_way    = WayW'(filled);
      limit      = filled;
      count      = filled + CntW'(1);
      move_tgt   = 1'b1;
      write_tag  = 1'b1;
      fill_row_d = filled + CntW'(1);
    end else begin
      outcome_d  = salc_pkg::OUT_EVICT;
      tgt_way    = vict_way;
      limit      = ways_m1;
      count      = filled;
      move_tgt   = vict_found;
      write_tag  = vict_found;
      fill_row_d = filled;
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      tag_row_d[w] = (write_tag && tgt_way == WayW'(w)) ? tag_q : tag_row_q[w];
      if (move_tgt && tgt_way == WayW'(w)) begin
        rank_row_d[w] = '0;
      end else if (CntW'(w) < count && CntW'(rank_row_q[w]) < limit) begin
        rank_row_d[w] = rank_row_q[w] + WayW'(1);
      end else begin
        rank_row_d[w] = rank_row_q[w];
      end
    end
  end

  // Memories and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      tag_row_q  <= tag_mem[set_idx];
      rank_row_q <= rank_mem[set_idx];
      fill_row_q <= fill_mem[set_idx];
      valid_q    <= set_vld_q[set_idx];
      set_q      <= set_idx;
      tag_q      <= tag_new;
    end
    if (cmd_i.commit) begin
      tag_mem[set_q]  <= tag_row_d;
      rank_mem[set_q] <= rank_row_d;
      fill_mem[set_q] <= fill_row_d;
      outcome_q       <= outcome_d;
    end
  end

  // Per-set valid bits: a set that was never written is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_vld_q <= '0;
    end else if (cmd_i.commit) begin
      set_vld_q[set_q] <= 1'b1;
    end
  end

  assign outcome_o = outcome_q;

endmodule

`default_nettype wire

### hw/rtl/set_assoc_lru_cache_tags_core.sv
// Top level of the set-associative cache tag store with true LRU replacement.
// A request is taken in the idle state; the lookup registers its set row, and the commit
// compares, updates and writes it back and registers the outcome, through single-port row
// memories. No new request is taken until the last one has been written back.
// A result left waiting on the response side holds the write-back until it is taken.
// Reset: registers return to 4 offset bits, 6 index bits, 8 ways; per-set valid bits
// clear at once, so all sets read as empty with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_tags_core #(
  parameter int unsigned MAX_WAYS       = salc_pkg::MaxWaysDef,
  parameter int unsigned MAX_INDEX_BITS = salc_pkg::MaxIndexBitsDef,
  parameter int unsigned ADDR_WIDTH     = salc_pkg::AddrWidthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  salc_req_if.sink                            req_i,
  salc_rsp_if.source                          rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [salc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [salc_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_WAYS + 1);
  localparam int unsigned IbW  = $clog2(MAX_INDEX_BITS + 1);

  // Configuration registers, stored as written
  logic [salc_pkg::OffsetRegW-1:0] offset_bits_q;
  logic [salc_pkg::IndexRegW-1:0]  index_bits_q;
  logic [salc_pkg::WaysRegW-1:0]   ways_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= salc_pkg::OffsetBitsRst;
      index_bits_q  <= salc_pkg::IndexBitsRst;
      ways_in_use_q <= salc_pkg::WaysInUseRst;
    end else if (cfg_we_i) begin
      unique case (salc_pkg::cfg_idx_e'(cfg_idx_i))
        salc_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
        salc_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i[salc_pkg::IndexRegW-1:0];
        salc_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data_i[salc_pkg::WaysRegW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Saturate each register into its legal range: zero counts as one,
  // anything above the maximum counts as the maximum.
  logic [salc_pkg::OffsetRegW-1:0] offset_eff;
  logic [IbW-1:0]                  index_eff;
  logic [CntW-1:0]                 ways_eff;

  always_comb begin
    priority if (offset_bits_q == '0) offset_eff = salc_pkg::OffsetRegW'(1);
    else if (offset_bits_q > salc_pkg::OffsetRegW'(salc_pkg::MaxOffsetBits))
      offset_eff = salc_pkg::OffsetRegW'(salc_pkg::MaxOffsetBits);
    else offset_eff = offset_bits_q;

    priority if (index_bits_q == '0) index_eff = IbW'(1);
    else if (32'(index_bits_q) > MAX_INDEX_BITS) index_eff = IbW'(MAX_INDEX_BITS);
    else index_eff = IbW'(index_bits_q);

    priority if (ways_in_use_q == '0) ways_eff = CntW'(1);
    else if (32'(ways_in_use_q) > MAX_WAYS) ways_eff = CntW'(MAX_WAYS);
    else ways_eff = CntW'(ways_in_use_q);
  end

  salc_pkg::cmd_t cmd;

  // Sequence each request: lookup, then commit once the result register is free
  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Hold the tag and recency rows; search, update and write back
  salc_datapath #(
    .MAX_WAYS       (MAX_WAYS),
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .ADDR_WIDTH     (ADDR_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .address_i     (req_i.address),
    .offset_bits_i (offset_eff),
    .index_bits_i  (index_eff),
    .ways_i        (ways_eff),
    .outcome_o     (rsp_o.outcome)
  );

endmodule

`default_nettype wire

### hw/rtl/salc_checker.sv
// Port-level checker of the LRU cache tag store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module salc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [salc_pkg::OutcomeW-1:0] outcome_i
);

  // one request in flight: an accepted request closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while another is in flight");

  // a pending lookup with a free result slot finishes in the next cycle
  a_lookup_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && (!out_valid_i || out_ready_i) |=> in_ready_i && out_valid_i)
    else $error("lookup did not complete when result slot was free");

  // no request in flight: a taken result leaves the output empty
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !in_valid_i && out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("result appeared without a request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(outcome_i))
    else $error("stalled result changed or dropped");

endmodule

bind set_assoc_lru_cache_tags_core salc_checker u_salc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .outcome_i   (rsp_o.outcome)
);

`default_nettype wire

### sim/set_assoc_lru_cache_tags_core_tb.sv
// Self-checking testbench for the LRU cache tag store: directed and random address streams.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags_core_tb;
  import salc_pkg::*;

  localparam int unsigned MAX_WAYS       = MaxWaysDef;
  localparam int unsigned MAX_INDEX_BITS = MaxIndexBitsDef;
  localparam int unsigned NumSets        = 1 << MAX_INDEX_BITS;
  localparam int unsigned NumLines       = NumSets * MAX_WAYS;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  salc_req_if req_if ();
  salc_rsp_if rsp_if ();

  set_assoc_lru_cache_tags_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the configuration registers, raw as written
  logic [OffsetRegW-1:0] offset_reg = OffsetBitsRst;
  logic [IndexRegW-1:0]  index_reg  = IndexBitsRst;
  logic [WaysRegW-1:0]   ways_reg   = WaysInUseRst;

  // Shadow tag store: valid lines per set, tag and recency rank per line
  int unsigned set_fill  [NumSets];
  logic [63:0] line_tag  [NumLines];
  int unsigned line_rank [NumLines];

  logic [63:0] address_backlog [$];   // requests waiting for the driver
  outcome_e    pending_outcomes [$];  // predicted outcomes, oldest first
  int unsigned fault_count = 0;

  // Send-side burst shaping and receive-side stall pattern
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  logic [15:0] ready_mask = 16'hFFFF;
  int unsigned ready_pos  = 0;

  // Clock and reset; every input holds a known value from time zero
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_OFFSET_BITS;
    cfg_data_i     = '0;
    req_if.valid   = 1'b0;
    req_if.address = '0;
    rsp_if.ready   = 1'b0;
    for (int unsigned s = 0; s < NumSets; s++) set_fill[s] = 0;
    fork
      forever #5 clk_i = ~clk_i;
      begin
        repeat (10) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  // Registers saturate into their legal range when used: zero reads as one
  function automatic int unsigned clamp_field(int unsigned value, int unsigned hi);
    if (value < 1) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  // Make 'way' most recent; every line of the set ranked below 'limit' ages by one
  function automatic void age_lines(int unsigned base, int unsigned filled,
                                    int unsigned way, int unsigned limit);
    for (int unsigned w = 0; w < filled; w++)
      if (line_rank[base + w] < limit) line_rank[base + w]++;
    line_rank[base + way] = 0;
  endfunction

  // Look one address up in the shadow store, update it and return the outcome
  function automatic outcome_e access_tag_store(logic [63:0] addr);
    int unsigned ob, ib, ways, set_no, base, filled;
    logic [63:0] tag;
    ob     = clamp_field(offset_reg, MaxOffsetBits);
    ib     = clamp_field(index_reg, MAX_INDEX_BITS);
    ways   = clamp_field(ways_reg, MAX_WAYS);
    set_no = (addr >> ob) & ((64'd1 << ib) - 1);
    tag    = addr >> (ob + ib);
    base   = set_no * MAX_WAYS;
    filled = (set_fill[set_no] > MAX_WAYS) ? MAX_WAYS : set_fill[set_no];

    // Only lines ranked inside the active ways may hit
    for (int unsigned w = 0; w < filled; w++) begin
      if (line_rank[base + w] < ways && line_tag[base + w] == tag) begin
        age_lines(base, filled, w, line_rank[base + w]);
        return OUT_HIT;
      end
    end

    // Free way left: fill the next one
    if (filled < ways) begin
      line_tag[base + filled]  = tag;
      line_rank[base + filled] = filled;
      age_lines(base, filled + 1, filled, filled);
      set_fill[set_no] = filled + 1;
      return OUT_FILL;
    end

    // Full: replace the line at the oldest active rank, deeper lines stay put
    for (int unsigned w = 0; w < filled; w++) begin
      if (line_rank[base + w] == ways - 1) begin
        line_tag[base + w] = tag;
        age_lines(base, filled, w, ways - 1);
        break;
      end
    end
    return OUT_EVICT;
  endfunction

  // Driver: predict on acceptance, then advance to the next request or a gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        pending_outcomes.push_back(access_tag_store(req_if.address));
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (address_backlog.size() > 0) begin
          req_if.valid   <= 1'b1;
          req_if.address <= address_backlog.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            // Mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted outcome against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_outcomes.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected outcome %0d with no request outstanding", rsp_if.outcome);
        end else begin
          outcome_e predicted;
          predicted = pending_outcomes.pop_front();
          if (rsp_if.outcome !== predicted) begin
            fault_count++;
            if (fault_count <= 10)
              $display("outcome mismatch: expected %s (%0d), got %0d",
                       predicted.name(), predicted, rsp_if.outcome);
          end
        end
      end
      // Walk a 16-bit stall mask; pick a fresh one at each wrap
      rsp_if.ready <= ready_mask[ready_pos];
      ready_pos = (ready_pos + 1) % 16;
      if (ready_pos == 0)
        ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    end
  end

  // Hold until the driver has nothing left and every outcome has come back
  task automatic wait_idle();
    while (address_backlog.size() != 0 || req_if.valid || pending_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_OFFSET_BITS: offset_reg = value[OffsetRegW-1:0];
      CFG_INDEX_BITS:  index_reg  = value[IndexRegW-1:0];
      CFG_WAYS_IN_USE: ways_reg   = value[WaysRegW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [CfgDataW-1:0] ob, logic [CfgDataW-1:0] ib,
                            logic [CfgDataW-1:0] ways);
    wait_idle();
    write_reg(CFG_OFFSET_BITS, ob);
    write_reg(CFG_INDEX_BITS, ib);
    write_reg(CFG_WAYS_IN_USE, ways);
  endtask

  // Mostly well-formed traffic: a small tag pool over a few sets so lines
  // are reused and evicted; the rest is fully random noise
  task automatic queue_random_phase(int unsigned n_items);
    logic [63:0] tag_pool [16];
    logic [63:0] addr;
    int unsigned ob, ib, ways, pool_size, set_no, pick;
    ob        = clamp_field(offset_reg, MaxOffsetBits);
    ib        = clamp_field(index_reg, MAX_INDEX_BITS);
    ways      = clamp_field(ways_reg, MAX_WAYS);
    pool_size = ways + 2;
    for (int unsigned i = 0; i < pool_size; i++)
      tag_pool[i] = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 15))
                                                : {$urandom, $urandom};
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        set_no = (pick < 65) ? $urandom_range(0, 3) : $urandom;
        set_no = set_no & ((1 << ib) - 1);
        addr   = (tag_pool[$urandom_range(0, pool_size - 1)] << (ob + ib))
               | (64'(set_no) << ob)
               | (64'($urandom) & ((64'd1 << ob) - 1));
      end else begin
        addr = {$urandom, $urandom};
      end
      address_backlog.push_back(addr);
    end
  endtask

  initial begin
    while (!rst_ni) @(posedge clk_i);

    // Directed, reset configuration (4 offset, 6 index bits, 8 ways: tag at bit 10)
    address_backlog.push_back(64'h0);                    // fill, set 0
    address_backlog.push_back(64'hFFFF_FFFF_FFFF_FFFF);  // fill, top set, widest tag
    address_backlog.push_back(64'h0);                    // hit
    address_backlog.push_back(64'hFFFF_FFFF_FFFF_FFFF);  // hit
    address_backlog.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    address_backlog.push_back(64'h5555_5555_5555_5555);
    // Fill set 0 to all eight ways, then overflow it twice
    for (int unsigned t = 1; t <= 9; t++) address_backlog.push_back(64'(t) << 10);
    address_backlog.push_back(64'h0);                    // evicted earlier: miss again
    address_backlog.push_back(64'd9 << 10);              // most recent: hit
    address_backlog.push_back(64'd3 << 10);              // old line still resident
    address_backlog.push_back(64'h000F);                 // offset bits ignored: hit
    queue_random_phase(90);

    // Smallest legal settings, then zeros that saturate to one
    set_config(5'd1, 5'd1, 5'd1);
    queue_random_phase(70);
    set_config(5'd0, 5'd0, 5'd0);
    queue_random_phase(50);

    // Largest legal settings, then out-of-range values that saturate to them
    set_config(5'd16, 5'd6, 5'd8);
    queue_random_phase(90);
    set_config(5'd31, 5'd7, 5'd15);
    queue_random_phase(70);

    // Four ways over four sets, then shrink the ways with sets already full
    set_config(5'd3, 5'd2, 5'd4);
    queue_random_phase(100);
    set_config(5'd3, 5'd2, 5'd2);
    queue_random_phase(80);

    // Raise the ways again so full-looking sets regain free ways
    set_config(5'd3, 5'd2, 5'd8);
    queue_random_phase(80);

    // Change the index width while sets keep their contents
    set_config(5'd3, 5'd3, 5'd6);
    queue_random_phase(80);
    set_config(5'd5, 5'd4, 5'd3);
    queue_random_phase(70);

    wait_idle();
    // Let any stray outcome surface before the verdict
    repeat (8) @(posedge clk_i);
    if (fault_count == 0 && pending_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
